// File: hdl/echo_extinction_leader_election_node_core_macros.svh
// Assertion helpers used by the checker of this block.
// Both expect signals named clk and arst_n in the scope where they are used.
`ifndef ECHO_EXTINCTION_LEADER_ELECTION_NODE_CORE_MACROS_SVH
`define ECHO_EXTINCTION_LEADER_ELECTION_NODE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EELE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EELE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/eele_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package eele_pkg;

	localparam int ROOT_W = 16;
	localparam int SRC_W  = 4;
	localparam int PCNT_W = 5;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		KIND_TEST    = 2'd0,
		KIND_REJECT  = 2'd1,
		KIND_ACK     = 2'd2,
		KIND_VICTORY = 2'd3
	} kind_t;

	typedef enum logic {
		CMD_START   = 1'b0,
		CMD_MESSAGE = 1'b1
	} cmd_t;

	typedef enum logic {
		REG_OWN_RANK   = 1'b0,
		REG_PORT_COUNT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [ROOT_W-1:0] own_rank;
		logic [PCNT_W-1:0] port_count;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic step;
		logic filter;
	} scan_ctl_t;

	typedef struct packed {
		logic busy;
		logic hit;
	} scan_st_t;

endpackage

`default_nettype wire

// File: hdl/eele_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface eele_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [1:0]  msg_kind;
	logic [3:0]  source_port;
	logic [15:0] msg_root;

	modport source (output valid, output command, output msg_kind, output source_port,
		output msg_root, input ready);
	modport sink (input valid, input command, input msg_kind, input source_port,
		input msg_root, output ready);
endinterface

`default_nettype wire

// File: hdl/eele_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface eele_out_if;
	logic        valid;
	logic        ready;
	logic        send_valid;
	logic [3:0]  dest_port;
	logic [1:0]  send_kind;
	logic [15:0] send_root;
	logic        leader_known;
	logic [15:0] leader_id;
	logic        last;

	modport source (output valid, output send_valid, output dest_port, output send_kind,
		output send_root, output leader_known, output leader_id, output last, input ready);
	modport sink (input valid, input send_valid, input dest_port, input send_kind,
		input send_root, input leader_known, input leader_id, input last, output ready);
endinterface

`default_nettype wire

// File: hdl/eele_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module eele_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [eele_pkg::ADDR_W-1:0]  paddr,
	input  logic [eele_pkg::DATA_W-1:0]  pwdata,
	output logic [eele_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output eele_pkg::cfg_t               cfg
);
	import eele_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t sel;
	logic     wr_en;

	assign sel    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_rank   <= '0;
			cfg_q.port_count <= PCNT_W'(16);
		end else if (wr_en) begin
			unique case (sel)
				REG_OWN_RANK:   cfg_q.own_rank   <= pwdata[ROOT_W-1:0];
				REG_PORT_COUNT: cfg_q.port_count <= pwdata[PCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			REG_OWN_RANK:   prdata = DATA_W'(cfg_q.own_rank);
			REG_PORT_COUNT: prdata = DATA_W'(cfg_q.port_count);
			default:        prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: hdl/eele_scan.sv
`timescale 1ns / 1ps
`default_nettype none

// Port scanner: visits one port per step and flags those that get a message.
module eele_scan #(
	parameter int PORTS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  eele_pkg::scan_ctl_t            ctl,
	input  logic [$clog2(PORTS+1)-1:0]     act,
	input  logic [PORTS-1:0]               rej,
	input  logic                           parent_valid,
	input  logic [eele_pkg::SRC_W-1:0]     parent,
	output eele_pkg::scan_st_t             st,
	output logic [$clog2(PORTS+1)-1:0]     idx
);
	import eele_pkg::*;

	localparam int IW = $clog2(PORTS + 1);
	localparam int XW = (PORTS > 1) ? $clog2(PORTS) : 1;
	localparam int CW = (IW > SRC_W) ? IW : SRC_W;

	logic [IW-1:0] idx_q;
	logic [XW-1:0] port_ix;
	logic          is_parent;

	assign port_ix   = idx_q[XW-1:0];
	assign is_parent = parent_valid && (CW'(idx_q) == CW'(parent));
	assign st.busy   = idx_q < act;
	assign st.hit    = st.busy && (!ctl.filter || (!rej[port_ix] && !is_parent));
	assign idx       = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (ctl.start) begin
			idx_q <= '0;
		end else if (ctl.step && st.busy) begin
			idx_q <= idx_q + IW'(1);
		end
	end

endmodule

`default_nettype wire

// File: hdl/echo_extinction_leader_election_node_core.sv
`timescale 1ns / 1ps
`default_nettype none

// One node of echo-with-extinction leader election. Configure own_rank (byte address 0)
// and port_count (byte address 4) over the APB-style port while the node is idle, then feed
// it words on cmd: a start command makes it an initiator, a message word carries a test,
// reject, ack or victory from a neighbour port. For each accepted word the node delivers on
// res one result word per outgoing message, in order, with last set on the final one; if
// nothing is sent it delivers a single null word (send_valid low). leader_known and
// leader_id on every result show whether the election has finished after that input. The
// node takes one input word at a time: cmd.ready is high only while it is idle. A word
// is accepted in the idle state and decided in the decide state; then come the two message
// phases (tests or one reject first, victories or one ack second), and the done state
// hands over the last result. A flood is sent by the port scanner, which visits one
// neighbour port per cycle while the result stage can take a message, once for a test
// flood and once for a victory flood. A single result stage sits between the scanner and
// the output register, so the scan can go on while the previous result waits to be taken,
// until the held result must wait as well. There is no clearing pass after reset.
module echo_extinction_leader_election_node_core #(
	parameter int PORTS   = 16,
	parameter int ID_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [eele_pkg::ADDR_W-1:0]  paddr,
	input  logic [eele_pkg::DATA_W-1:0]  pwdata,
	output logic [eele_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	eele_in_if.sink                      cmd,
	eele_out_if.source                   res
);
	import eele_pkg::*;

	localparam int IW = $clog2(PORTS + 1);
	localparam int XW = (PORTS > 1) ? $clog2(PORTS) : 1;
	localparam int CW = (IW > SRC_W) ? IW : SRC_W;
	localparam logic [ROOT_W-1:0] ID_MASK = (ID_BITS >= ROOT_W) ? {ROOT_W{1'b1}} :
		ROOT_W'((64'd1 << ID_BITS) - 64'd1);

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECIDE = 5'b00010,
		ST_PH1    = 5'b00100,
		ST_PH2    = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	// What the first phase sends: a test flood or one reject.
	typedef enum logic [1:0] {
		P1_NONE   = 2'd0,
		P1_TEST   = 2'd1,
		P1_REJECT = 2'd2
	} ph1_t;

	// What the second phase sends: a victory flood or one ack to the parent.
	typedef enum logic [1:0] {
		P2_NONE    = 2'd0,
		P2_VICTORY = 2'd1,
		P2_ACK     = 2'd2
	} ph2_t;

	cfg_t cfg;

	eele_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	state_t state_q, state_d;

	// Latched input word.
	cmd_t              cmd_q;
	kind_t             kind_q;
	logic [SRC_W-1:0]  src_q;
	logic [ROOT_W-1:0] root_in_q;

	// Election state.
	logic              root_valid_q;
	logic [ROOT_W-1:0] best_root_q;
	logic              parent_valid_q;
	logic [SRC_W-1:0]  parent_q;
	logic [7:0]        pending_q;
	logic [PORTS-1:0]  rej_q;
	logic              finished_q;

	// Plan for the current word.
	ph1_t ph1_q;
	ph2_t ph2_q;
	logic scan_all_q;

	// Result staging: one held result, then the output register.
	logic [IW-1:0]     cnt_q;
	logic              hold_v_q;
	logic [SRC_W-1:0]  hold_dest_q;
	kind_t             hold_kind_q;
	logic              out_v_q;
	logic              out_send_q;
	logic [SRC_W-1:0]  out_dest_q;
	kind_t             out_kind_q;
	logic [ROOT_W-1:0] out_root_q;
	logic              out_lk_q;
	logic [ROOT_W-1:0] out_lid_q;
	logic              out_last_q;

	logic [IW-1:0]     act;
	logic [ROOT_W-1:0] rank;
	logic [XW-1:0]     src_x;
	logic              src_ok;
	logic [PORTS-1:0]  elig;
	logic              any_elig;

	// Decision outputs.
	ph1_t              d_ph1;
	ph2_t              d_ph2;
	logic              d_all;
	logic              d_root_valid;
	logic [ROOT_W-1:0] d_best;
	logic              d_parent_valid;
	logic [7:0]        d_pending;
	logic              d_finished;
	logic              d_adopt;
	logic              d_reject_src;
	logic              dec;
	logic              zero;

	// Sequencer signals.
	scan_ctl_t         scan_ctl;
	scan_st_t          scan_st;
	logic [IW-1:0]     scan_idx;
	logic              can_push;
	logic              gen_ok;
	logic              ph1_leave;
	logic              ph2_leave;
	logic              cand_v;
	logic [SRC_W-1:0]  cand_dest;
	kind_t             cand_kind;
	logic              emit;
	logic              push_mid;
	logic              done_push;
	logic              load_out;
	logic              pend_inc;

	// Ports in use: a count above the built number of ports acts as that number.
	always_comb begin
		if (32'(cfg.port_count) > PORTS) begin
			act = IW'(PORTS);
		end else begin
			act = IW'(cfg.port_count);
		end
	end

	assign rank   = cfg.own_rank & ID_MASK;
	assign src_x  = XW'(src_q);
	assign src_ok = (CW'(src_q) < CW'(act)) && !rej_q[src_x];

	// Ports that an adopted test would flood; if none, the node is a leaf of the new tree.
	always_comb begin
		for (int i = 0; i < PORTS; i++) begin
			elig[i] = (CW'(i) < CW'(act)) && !rej_q[i] && (CW'(i) != CW'(src_q));
		end
	end
	assign any_elig = |elig;

	// Everything the word does to the state is settled in the decide cycle; only the
	// pending count of a test flood is counted up while the flood goes out.
	always_comb begin
		d_ph1          = P1_NONE;
		d_ph2          = P2_NONE;
		d_all          = 1'b0;
		d_root_valid   = root_valid_q;
		d_best         = best_root_q;
		d_parent_valid = parent_valid_q;
		d_pending      = pending_q;
		d_finished     = finished_q;
		d_adopt        = 1'b0;
		d_reject_src   = 1'b0;
		dec            = 1'b0;
		zero           = 1'b0;
		if (!finished_q) begin
			if (cmd_q == CMD_START) begin
				d_ph1          = P1_TEST;
				d_all          = 1'b1;
				d_root_valid   = 1'b1;
				d_best         = rank;
				d_parent_valid = 1'b0;
				d_pending      = '0;
			end else if (src_ok) begin
				if (kind_q == KIND_VICTORY) begin
					d_ph2        = P2_VICTORY;
					d_best       = root_in_q;
					d_root_valid = 1'b1;
					d_finished   = 1'b1;
				end else begin
					unique case (kind_q)
						KIND_TEST: begin
							if (!root_valid_q || root_in_q > best_root_q) begin
								d_adopt        = 1'b1;
								d_ph1          = P1_TEST;
								d_root_valid   = 1'b1;
								d_best         = root_in_q;
								d_parent_valid = 1'b1;
							end else if (root_in_q == best_root_q) begin
								d_ph1        = P1_REJECT;
								d_reject_src = 1'b1;
								dec          = 1'b1;
							end
						end
						KIND_REJECT: begin
							d_reject_src = 1'b1;
							dec          = 1'b1;
						end
						KIND_ACK: begin
							dec = root_valid_q && (root_in_q == best_root_q);
						end
						KIND_VICTORY: begin
						end
						default: begin
						end
					endcase
					if (d_adopt) begin
						d_pending = '0;
						zero      = !any_elig;
					end else begin
						d_pending = pending_q - 8'(dec);
						zero      = (d_pending == 8'd0);
					end
					// Nothing outstanding: the own root wins, otherwise report to the parent.
					if (zero) begin
						if (d_root_valid && d_best == rank) begin
							d_ph2      = P2_VICTORY;
							d_finished = 1'b1;
						end else if (d_parent_valid) begin
							d_ph2 = P2_ACK;
						end
					end
				end
			end
		end
	end

	eele_scan #(
		.PORTS (PORTS)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (scan_ctl),
		.act          (act),
		.rej          (rej_q),
		.parent_valid (parent_valid_q),
		.parent       (parent_q),
		.st           (scan_st),
		.idx          (scan_idx)
	);

	// The output register frees up when it is empty or being taken; the held result can
	// move whenever that is so; that, or an empty hold, lets a new result be produced.
	assign can_push = !out_v_q || res.ready;
	assign gen_ok   = !hold_v_q || can_push;

	always_comb begin
		ph1_leave = 1'b0;
		ph2_leave = 1'b0;
		cand_v    = 1'b0;
		cand_dest = '0;
		cand_kind = KIND_TEST;
		pend_inc  = 1'b0;
		scan_ctl.step   = 1'b0;
		scan_ctl.filter = 1'b1;
		if (state_q == ST_PH1) begin
			scan_ctl.filter = !scan_all_q;
			unique case (ph1_q)
				P1_TEST: begin
					scan_ctl.step = gen_ok;
					cand_v        = gen_ok && scan_st.hit;
					cand_dest     = SRC_W'(scan_idx);
					cand_kind     = KIND_TEST;
					pend_inc      = gen_ok && scan_st.hit;
					ph1_leave     = !scan_st.busy;
				end
				P1_REJECT: begin
					cand_v    = gen_ok;
					cand_dest = src_q;
					cand_kind = KIND_REJECT;
					ph1_leave = gen_ok;
				end
				default: ph1_leave = 1'b1;
			endcase
		end else if (state_q == ST_PH2) begin
			unique case (ph2_q)
				P2_VICTORY: begin
					scan_ctl.step = gen_ok;
					cand_v        = gen_ok && scan_st.hit;
					cand_dest     = SRC_W'(scan_idx);
					cand_kind     = KIND_VICTORY;
					ph2_leave     = !scan_st.busy;
				end
				P2_ACK: begin
					cand_v    = gen_ok;
					cand_dest = parent_q;
					cand_kind = KIND_ACK;
					ph2_leave = gen_ok;
				end
				default: ph2_leave = 1'b1;
			endcase
		end
		scan_ctl.start = (state_q == ST_DECIDE) || (state_q == ST_PH1 && ph1_leave);
	end

	// At most PORTS messages per word; the pending count still follows every test.
	assign emit      = cand_v && (cnt_q != IW'(PORTS));
	assign push_mid  = emit && hold_v_q;
	assign done_push = (state_q == ST_DONE) && can_push;
	assign load_out  = push_mid || done_push;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (cmd.valid) state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_PH1;
			ST_PH1:    if (ph1_leave) state_d = ST_PH2;
			ST_PH2:    if (ph2_leave) state_d = ST_DONE;
			ST_DONE:   if (can_push) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	assign cmd.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			root_valid_q   <= 1'b0;
			parent_valid_q <= 1'b0;
			pending_q      <= '0;
			rej_q          <= '0;
			finished_q     <= 1'b0;
			ph1_q          <= P1_NONE;
			ph2_q          <= P2_NONE;
			scan_all_q     <= 1'b0;
			cnt_q          <= '0;
			hold_v_q       <= 1'b0;
			out_v_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DECIDE) begin
				ph1_q          <= d_ph1;
				ph2_q          <= d_ph2;
				scan_all_q     <= d_all;
				cnt_q          <= '0;
				root_valid_q   <= d_root_valid;
				parent_valid_q <= d_parent_valid;
				pending_q      <= d_pending;
				finished_q     <= d_finished;
				if (d_reject_src) begin
					rej_q[src_x] <= 1'b1;
				end
			end
			if (pend_inc) begin
				pending_q <= pending_q + 8'd1;
			end
			if (emit) begin
				hold_v_q <= 1'b1;
				cnt_q    <= cnt_q + IW'(1);
			end else if (done_push) begin
				hold_v_q <= 1'b0;
			end
			if (load_out) begin
				out_v_q <= 1'b1;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_q     <= cmd_t'(cmd.command);
			kind_q    <= kind_t'(cmd.msg_kind);
			src_q     <= cmd.source_port;
			root_in_q <= cmd.msg_root & ID_MASK;
		end
		if (state_q == ST_DECIDE) begin
			best_root_q <= d_best;
			if (d_adopt) begin
				parent_q <= src_q;
			end
		end
		if (emit) begin
			hold_dest_q <= cand_dest;
			hold_kind_q <= cand_kind;
		end
		// Every message of a word carries the node's root as it stands after the decision.
		if (load_out) begin
			out_lk_q  <= finished_q;
			out_lid_q <= finished_q ? best_root_q : '0;
			if (hold_v_q) begin
				out_send_q <= 1'b1;
				out_dest_q <= hold_dest_q;
				out_kind_q <= hold_kind_q;
				out_root_q <= best_root_q;
			end else begin
				out_send_q <= 1'b0;
				out_dest_q <= '0;
				out_kind_q <= KIND_TEST;
				out_root_q <= '0;
			end
			out_last_q <= done_push;
		end
	end

	assign res.valid        = out_v_q;
	assign res.send_valid   = out_send_q;
	assign res.dest_port    = out_dest_q;
	assign res.send_kind    = out_kind_q;
	assign res.send_root    = out_root_q;
	assign res.leader_known = out_lk_q;
	assign res.leader_id    = out_lid_q;
	assign res.last         = out_last_q;

endmodule

`default_nettype wire

// File: hdl/eele_chk.sv
`timescale 1ns / 1ps
`default_nettype none

`include "echo_extinction_leader_election_node_core_macros.svh"

module eele_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic        res_send_valid,
	input logic [3:0]  res_dest_port,
	input logic [1:0]  res_send_kind,
	input logic [15:0] res_send_root,
	input logic        res_leader_known,
	input logic [15:0] res_leader_id,
	input logic        res_last
);
	logic [40:0] res_word;

	assign res_word = {res_send_valid, res_dest_port, res_send_kind, res_send_root,
		res_leader_known, res_leader_id, res_last};

	`EELE_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_word), "result word changed while stalled")
	`EELE_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "node took a second word without finishing the first")
	`EELE_ASSERT_SAME(a_null_is_last, res_valid && !res_send_valid, res_last, "null result not marked last")
	`EELE_ASSERT_SAME(a_leader_clear, res_valid && !res_leader_known, res_leader_id == 16'd0, "leader id shown before the election finished")

endmodule

bind echo_extinction_leader_election_node_core eele_chk u_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_send_valid   (res.send_valid),
	.res_dest_port    (res.dest_port),
	.res_send_kind    (res.send_kind),
	.res_send_root    (res.send_root),
	.res_leader_known (res.leader_known),
	.res_leader_id    (res.leader_id),
	.res_last         (res.last)
);

`default_nettype wire
